@@ rtl/core/dhle_pkg.sv @@
// Shared constants and types for the DNS host-name label encoder.
package dhle_pkg;

    // Default number of characters one label can hold.
    localparam int LABEL_CAP_DEF = 61;

    localparam int BYTE_W = 8;

    // Character that separates labels.
    localparam logic [BYTE_W-1:0] DOT_CODE = 8'h2E;

    // Byte that closes an encoded name.
    localparam logic [BYTE_W-1:0] TERM_CODE = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHARS,
        ST_TERM
    } enc_state_t;

endpackage

@@ rtl/core/dhle_cell.sv @@
// One character cell of the label buffer chain.
module dhle_cell (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [dhle_pkg::BYTE_W-1:0]   wr_data,
    input  logic                          shift_en,
    input  logic [dhle_pkg::BYTE_W-1:0]   neighbor_data,
    output logic [dhle_pkg::BYTE_W-1:0]   data_out
);

    logic [dhle_pkg::BYTE_W-1:0] data_reg;
    logic [dhle_pkg::BYTE_W-1:0] data_next;

    // A cell takes the incoming character when selected, or its upper
    // neighbor's byte when the chain moves toward the output.
    always_comb begin
        data_next = data_reg;
        if (wr_en) begin
            data_next = wr_data;
        end else if (shift_en) begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

@@ rtl/core/dns_hostname_label_encoder.sv @@
// Top level of the DNS host-name label encoder: cell chain and control.
//
// The s_ channel takes one host-name character per transaction in s_tdata,
// with s_tlast set on the final character. The m_ channel delivers the
// wire-format bytes: a length byte and the characters of each label, and a
// zero byte closing the name. m_tlast marks the last byte caused by one
// input transaction.
// A character other than a dot that is not final is stored, or dropped and
// the label flagged as truncated once it is full; the encoder stays ready
// for the next character. A label closed by a dot or the final character is
// sent as one byte per cycle while the receiver takes them: a length byte,
// then its characters from the head of the cell chain, and at the end the
// terminator; input is held off meanwhile. Accepting the closing character
// moves the state to the length state, which then registers the length byte.
// Reset clears the control state and the output valid flag; the output data
// and cell contents are not cleared and are only read after being written.
// When the receiver stalls, the output register holds its byte and the
// encoder waits; characters that cause no output are still taken meanwhile.
module dns_hostname_label_encoder #(
    parameter int LABEL_CAP = dhle_pkg::LABEL_CAP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] label_truncated, [1] name_complete
);

    localparam int LEN_W = $clog2(LABEL_CAP + 1);

    dhle_pkg::enc_state_t state_reg, state_next;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             second_reg, second_next;
    logic             term_reg, term_next;

    logic                        m_tvalid_reg;
    logic [dhle_pkg::BYTE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;

    logic load_out;
    logic slot_free;
    logic wr_en;
    logic shift_en;

    logic [dhle_pkg::BYTE_W-1:0] cell_q [LABEL_CAP];

    // Cell chain: writes land at the current length, reads come from cell 0.
    genvar k;
    generate
        for (k = 0; k < LABEL_CAP; k++) begin : g_cell
            logic [dhle_pkg::BYTE_W-1:0] upper;
            if (k == LABEL_CAP - 1) begin : g_top
                assign upper = '0;
            end else begin : g_mid
                assign upper = cell_q[k+1];
            end
            dhle_cell u_cell (
                .aclk          (aclk),
                .wr_en         (wr_en && (len_reg == LEN_W'(k))),
                .wr_data       (s_tdata),
                .shift_en      (shift_en),
                .neighbor_data (upper),
                .data_out      (cell_q[k])
            );
        end
    endgenerate

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        second_next  = second_reg;
        term_next    = term_reg;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        shift_en     = 1'b0;
        m_tdata_next = m_tdata_reg;
        m_tlast_next = m_tlast_reg;
        m_tuser_next = m_tuser_reg;
        s_tready     = (state_reg == dhle_pkg::ST_IDLE);

        case (state_reg)
            dhle_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata == dhle_pkg::DOT_CODE) begin
                        // A final dot closes this label and then an empty one.
                        second_next = s_tlast;
                        term_next   = s_tlast;
                        state_next  = dhle_pkg::ST_LEN;
                    end else begin
                        if (len_reg < LEN_W'(LABEL_CAP)) begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (s_tlast) begin
                            second_next = 1'b0;
                            term_next   = 1'b1;
                            state_next  = dhle_pkg::ST_LEN;
                        end
                    end
                end
            end
            dhle_pkg::ST_LEN: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    m_tdata_next = dhle_pkg::BYTE_W'(len_reg);
                    m_tuser_next = {1'b0, ovf_reg};
                    m_tlast_next = (len_reg == '0) && !second_reg && !term_reg;
                    if (len_reg == '0) begin
                        ovf_next = 1'b0;
                        if (second_reg) begin
                            second_next = 1'b0;
                            state_next  = dhle_pkg::ST_LEN;
                        end else if (term_reg) begin
                            state_next = dhle_pkg::ST_TERM;
                        end else begin
                            state_next = dhle_pkg::ST_IDLE;
                        end
                    end else begin
                        state_next = dhle_pkg::ST_CHARS;
                    end
                end
            end
            dhle_pkg::ST_CHARS: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    shift_en     = 1'b1;
                    m_tdata_next = cell_q[0];
                    m_tuser_next = {1'b0, ovf_reg};
                    len_next     = len_reg - LEN_W'(1);
                    m_tlast_next = (len_reg == LEN_W'(1)) && !second_reg && !term_reg;
                    if (len_reg == LEN_W'(1)) begin
                        ovf_next = 1'b0;
                        if (second_reg) begin
                            second_next = 1'b0;
                            state_next  = dhle_pkg::ST_LEN;
                        end else if (term_reg) begin
                            state_next = dhle_pkg::ST_TERM;
                        end else begin
                            state_next = dhle_pkg::ST_IDLE;
                        end
                    end
                end
            end
            dhle_pkg::ST_TERM: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    m_tdata_next = dhle_pkg::TERM_CODE;
                    m_tuser_next = 2'b10;
                    m_tlast_next = 1'b1;
                    term_next    = 1'b0;
                    state_next   = dhle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dhle_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dhle_pkg::ST_IDLE;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            second_reg   <= 1'b0;
            term_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            second_reg <= second_next;
            term_reg   <= term_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ dv/dns_hostname_label_encoder_test.sv @@
// Self-checking testbench for the DNS host-name label encoder.
module dns_hostname_label_encoder_test;

    localparam int LABEL_CAP      = dhle_pkg::LABEL_CAP_DEF;
    localparam int RANDOM_ITEMS   = 110;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 50;
    localparam int USE_MODEL      = -1;
    localparam int NUM_DIRECTED   = 20;

    // One encoded byte as seen on the m_ channel.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       cut;
        logic       done;
    } enc_byte_t;

    typedef struct {
        logic [7:0]        code;
        logic              last;
        int                n_typed;   // USE_MODEL: expectation comes from the predictor
        enc_byte_t [0:2]   typed;
    } dir_row_t;

    localparam enc_byte_t NONE       = '0;
    localparam enc_byte_t EMPTY      = '{dhle_pkg::TERM_CODE, 1'b0, 1'b0, 1'b0};
    localparam enc_byte_t EMPTY_LAST = '{dhle_pkg::TERM_CODE, 1'b1, 1'b0, 1'b0};
    localparam enc_byte_t LEN1       = '{8'h01, 1'b0, 1'b0, 1'b0};
    localparam enc_byte_t TERM       = '{dhle_pkg::TERM_CODE, 1'b1, 1'b0, 1'b1};

    dir_row_t dir_rows [NUM_DIRECTED] = '{
        '{dhle_pkg::DOT_CODE, 1'b0, 1, '{EMPTY_LAST, NONE, NONE}},   // leading dot
        '{dhle_pkg::DOT_CODE, 1'b1, 3, '{EMPTY, EMPTY, TERM}},       // final dot
        '{8'h00,    1'b1, 3, '{LEN1, EMPTY, TERM}},               // zero char is a label char
        '{8'hFF,    1'b1, 3, '{LEN1, '{8'hFF, 1'b0, 1'b0, 1'b0}, TERM}},
        '{8'h77,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'h77,    1'b0, 0, '{NONE, NONE, NONE}},
        '{dhle_pkg::DOT_CODE, 1'b0, USE_MODEL, '{NONE, NONE, NONE}},
        '{dhle_pkg::DOT_CODE, 1'b0, USE_MODEL, '{NONE, NONE, NONE}}, // adjacent dots
        '{8'h7F,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'h80,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'h01,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'hFE,    1'b1, USE_MODEL, '{NONE, NONE, NONE}},
        '{8'h78,    1'b0, 0, '{NONE, NONE, NONE}},
        '{dhle_pkg::DOT_CODE, 1'b1, USE_MODEL, '{NONE, NONE, NONE}},
        '{8'h61,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'h62,    1'b1, USE_MODEL, '{NONE, NONE, NONE}},
        '{8'h55,    1'b0, 0, '{NONE, NONE, NONE}},
        '{8'hAA,    1'b0, 0, '{NONE, NONE, NONE}},
        '{dhle_pkg::DOT_CODE, 1'b0, USE_MODEL, '{NONE, NONE, NONE}},
        '{8'h71,    1'b1, USE_MODEL, '{NONE, NONE, NONE}}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;
    logic [1:0] m_tuser;            // [0] label_truncated, [1] name_complete

    dns_hostname_label_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: the label being collected.
    logic [7:0] held_chars [LABEL_CAP];
    int         held_count = 0;
    bit         held_cut   = 1'b0;

    enc_byte_t  step_bytes [$];
    enc_byte_t  wire_bytes_due [$];

    int  err_count    = 0;
    int  chars_sent   = 0;
    int  bytes_seen   = 0;
    int  names_closed = 0;
    int  cut_bytes    = 0;
    int  idle_cycles  = 0;
    int  stall_left   = 0;
    int  stall_draw;
    bit  no_idle      = 1'b0;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] rand_label_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
            return 8'(8'h61 + $urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (c == dhle_pkg::DOT_CODE);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (output byte %0d)",
                     what, got, want, bytes_seen);
        err_count++;
    endtask

    // Emit the pending label as a length byte and its characters.
    task automatic close_label();
        step_bytes.push_back('{8'(held_count), 1'b0, held_cut, 1'b0});
        for (int i = 0; i < held_count; i++)
            step_bytes.push_back('{held_chars[i], 1'b0, held_cut, 1'b0});
        held_count = 0;
        held_cut   = 1'b0;
    endtask

    task automatic encode_char(input logic [7:0] c, input logic last);
        enc_byte_t tail;
        step_bytes.delete();
        if (c == dhle_pkg::DOT_CODE) begin
            close_label();
        end else if (held_count < LABEL_CAP) begin
            held_chars[held_count] = c;
            held_count++;
        end else begin
            held_cut = 1'b1;
        end
        if (last) begin
            close_label();
            step_bytes.push_back(TERM);
        end
        if (step_bytes.size() > 0) begin
            tail = step_bytes.pop_back();
            tail.run_end = 1'b1;
            step_bytes.push_back(tail);
        end
    endtask

    // Drive one character and wait for its transaction. Valid is left high so
    // that a back-to-back character needs no second assignment in this step.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        encode_char(c, last);
    endtask

    // One host name: mostly well-formed labels, sometimes random noise.
    task automatic send_name(input int forced_len);
        logic [7:0] chars [$];
        int n_labels;
        int len;
        if (forced_len > 0) begin
            repeat (forced_len) chars.push_back(rand_label_char());
        end else if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 12);
            repeat (len)
                chars.push_back(($urandom_range(0, 2) == 0) ? dhle_pkg::DOT_CODE
                                                            : 8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 9) == 0)
                chars.push_back(dhle_pkg::DOT_CODE);
            n_labels = $urandom_range(1, 4);
            for (int l = 0; l < n_labels; l++) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(58, 64)
                                                   : $urandom_range(0, 8);
                repeat (len) chars.push_back(rand_label_char());
                if (l < n_labels - 1)
                    chars.push_back(dhle_pkg::DOT_CODE);
            end
            if ($urandom_range(0, 6) == 0)
                chars.push_back(dhle_pkg::DOT_CODE);
        end
        if (chars.size() == 0)
            chars.push_back(rand_label_char());
        for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], i == chars.size() - 1);
            wire_bytes_due = {wire_bytes_due, step_bytes};
        end
    endtask

    // Receiver: a fresh stall is drawn after every accepted byte.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            stall_draw = draw_wait();
            stall_left <= stall_draw;
            m_tready   <= (stall_draw == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        enc_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (wire_bytes_due.size() == 0) begin
                report_mismatch("byte with nothing expected", m_tdata, 0);
            end else begin
                want = wire_bytes_due.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", m_tdata, want.data);
                if (m_tlast !== want.run_end)
                    report_mismatch("run_end", m_tlast, want.run_end);
                if (m_tuser[0] !== want.cut)
                    report_mismatch("label_truncated", m_tuser[0], want.cut);
                if (m_tuser[1] !== want.done)
                    report_mismatch("name_complete", m_tuser[1], want.done);
            end
            bytes_seen++;
            if (m_tuser[1] === 1'b1)
                names_closed++;
            if (m_tuser[0] === 1'b1)
                cut_bytes++;
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int start_count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            send_char(dir_rows[r].code, dir_rows[r].last);
            if (dir_rows[r].n_typed == USE_MODEL) begin
                wire_bytes_due = {wire_bytes_due, step_bytes};
            end else begin
                for (int k = 0; k < dir_rows[r].n_typed; k++)
                    wire_bytes_due.push_back(dir_rows[r].typed[k]);
            end
        end

        // A label longer than the capacity comes first, then random names.
        start_count = chars_sent;
        send_name(63);
        while (chars_sent - start_count < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_name(0);
        end
        no_idle = 1'b0;

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (wire_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters; checked %0d encoded bytes over %0d names.",
                 chars_sent, bytes_seen, names_closed);
        $display("Bytes flagged as part of a cut label: %0d; mismatches: %0d.",
                 cut_bytes, err_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ dns_hostname_label_encoder.f @@
rtl/core/dhle_pkg.sv
rtl/core/dhle_cell.sv
rtl/core/dns_hostname_label_encoder.sv
dv/dns_hostname_label_encoder_test.sv
